// ----- rtl/core/edc_pkg.sv -----
// Package for the epoch-seconds to UTC date converter.
// Holds the transfer payload types, calendar constants, reciprocal multipliers
// and the month offset table. It depends on nothing else.
package edc_pkg;

    // Payload of one input transfer.
    typedef struct packed {
        logic [31:0] epoch_seconds;
    } t_time_item;

    // Payload of one output transfer.
    typedef struct packed {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] calendar_year;
        logic [2:0]  weekday;
    } t_date_item;

    // Calendar constants.
    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned SECS_PER_HOUR  = 3600;
    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned DAYS_PER_WEEK  = 7;
    localparam int unsigned EPOCH_WEEKDAY  = 4;
    localparam int unsigned DAYS_TO_EPOCH  = 719527;
    localparam int unsigned JAN_FEB_DAYS   = 59;
    localparam int unsigned DAYS_IN_400Y   = 146097;
    localparam int unsigned MARCH_BASE_DAY = 306;

    // Days since 1970 plus this offset gives days since March 1 of year 0.
    localparam int unsigned MARCH_DAY_OFS = DAYS_TO_EPOCH - JAN_FEB_DAYS;

    // Reciprocal multipliers: floor(x / d) == (x * ceil(2^k / d)) >> k, exact
    // whenever x < 2^(k - ceil(log2 d)).
    // Days: the seconds count is shifted right by 7 first, leaving x / 675.
    localparam int unsigned DAY_SHIFT  = 35;
    localparam longint unsigned DAY_RECIP_L = ((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675;
    localparam logic [25:0] DAY_RECIP  = 26'(DAY_RECIP_L);

    // Weekday: quotient by 7 of a 16-bit day count.
    localparam int unsigned WDAY_SHIFT = 19;
    localparam longint unsigned WDAY_RECIP_L = ((64'd1 << WDAY_SHIFT) + 64'd6) / 64'd7;
    localparam logic [16:0] WDAY_RECIP = 17'(WDAY_RECIP_L);

    // Hour: quotient by 3600 of a 17-bit second count.
    localparam int unsigned HOUR_SHIFT = 29;
    localparam longint unsigned HOUR_RECIP_L = ((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600;
    localparam logic [17:0] HOUR_RECIP = 18'(HOUR_RECIP_L);

    // Minute: quotient by 60 of a 12-bit second count.
    localparam int unsigned MIN_SHIFT  = 18;
    localparam longint unsigned MIN_RECIP_L = ((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60;
    localparam logic [12:0] MIN_RECIP  = 13'(MIN_RECIP_L);

    // Year estimate: (days + 2) * 400 / 146097, the factor 400 folded in.
    localparam int unsigned YEAR_SHIFT = 47;
    localparam longint unsigned YEAR_BASE_L =
        ((64'd1 << YEAR_SHIFT) + 64'(DAYS_IN_400Y) - 64'd1) / 64'(DAYS_IN_400Y);
    localparam logic [38:0] YEAR_RECIP = 39'(YEAR_BASE_L * 64'd400);

    // Century: quotient by 100 of a 12-bit year.
    localparam int unsigned CENT_SHIFT = 19;
    localparam longint unsigned CENT_RECIP_L = ((64'd1 << CENT_SHIFT) + 64'd99) / 64'd100;
    localparam logic [12:0] CENT_RECIP = 13'(CENT_RECIP_L);

    // Month: (yday + 31) * 10 / 306, the factor 10 folded in.
    localparam int unsigned MON_SHIFT  = 21;
    localparam longint unsigned MON_BASE_L =
        ((64'd1 << MON_SHIFT) + 64'(MARCH_BASE_DAY) - 64'd1) / 64'(MARCH_BASE_DAY);
    localparam logic [16:0] MON_RECIP  = 17'(MON_BASE_L * 64'd10);

    // Day-of-year at which a March-based month starts, 367 * m / 12 - 30.
    // Month zero never occurs.
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] ofs;
        case (mon)
            4'd1:    ofs = 9'd0;
            4'd2:    ofs = 9'd31;
            4'd3:    ofs = 9'd61;
            4'd4:    ofs = 9'd92;
            4'd5:    ofs = 9'd122;
            4'd6:    ofs = 9'd153;
            4'd7:    ofs = 9'd184;
            4'd8:    ofs = 9'd214;
            4'd9:    ofs = 9'd245;
            4'd10:   ofs = 9'd275;
            4'd11:   ofs = 9'd306;
            4'd12:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

// ----- rtl/core/edc_stream_if.sv -----
// Valid/ready stream interface used by both channels of the date converter.
// The payload type is a parameter; the types come from edc_pkg.
interface edc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/epoch_seconds_to_utc_date.sv -----
// Top level of the epoch-seconds to UTC date converter, a nine-stage pipeline.
// Depends on edc_pkg for types and constants and on edc_stream_if for ports.
//
//  Port    Dir  Payload       Contents
//  i_time  in   t_time_item   seconds since 1970-01-01 00:00:00 UTC
//  o_date  out  t_date_item   second, minute, hour, day, month, year, weekday
//
// An input transfer moves through the stage registers in order into the output
// register. One item is taken every cycle unless output stalls; each stage
// holds a few multiplications by constants or a short add-and-compare.
// The whole pipeline advances when the output register is empty or taken;
// while the output is stalled every stage holds, so nothing is lost.
// Reset clears the stage valid bits only.
module epoch_seconds_to_utc_date (
    input  logic               i_clk,
    input  logic               i_rst_n,
    edc_stream_if.sink         i_time,
    edc_stream_if.source       o_date
);

    localparam int unsigned NUM_STAGES = 9;

    logic [NUM_STAGES-1:0] r_vld;
    logic                  w_adv;

    // Stage registers.
    logic [31:0]        r_s0_secs;
    logic [31:0]        r_s1_secs;
    logic [15:0]        r_s1_days;
    logic [16:0]        r_s2_rem;
    logic [19:0]        r_s2_dnum;
    logic [16:0]        r_s2_wd_t;
    logic [12:0]        r_s2_wd_q;
    logic [16:0]        r_s3_rem;
    logic [4:0]         r_s3_hour;
    logic [2:0]         r_s3_wday;
    logic [19:0]        r_s3_dnum;
    logic [11:0]        r_s3_yest;
    logic [11:0]        r_s4_rsec;
    logic [4:0]         r_s4_hour;
    logic [2:0]         r_s4_wday;
    logic [19:0]        r_s4_dnum;
    logic [11:0]        r_s4_yest;
    logic [4:0]         r_s4_y100;
    logic [19:0]        r_s4_y365;
    logic [11:0]        r_s5_rsec;
    logic [5:0]         r_s5_min;
    logic [4:0]         r_s5_hour;
    logic [2:0]         r_s5_wday;
    logic signed [10:0] r_s5_yday_raw;
    logic               r_s5_leap;
    logic [11:0]        r_s5_yest;
    logic [5:0]         r_s6_sec;
    logic [5:0]         r_s6_min;
    logic [4:0]         r_s6_hour;
    logic [2:0]         r_s6_wday;
    logic [8:0]         r_s6_yday;
    logic [11:0]        r_s6_year;
    logic [5:0]         r_s7_sec;
    logic [5:0]         r_s7_min;
    logic [4:0]         r_s7_hour;
    logic [2:0]         r_s7_wday;
    logic [8:0]         r_s7_yday;
    logic [11:0]        r_s7_year;
    logic [3:0]         r_s7_mon;
    edc_pkg::t_date_item r_out;

    // Next values.
    logic [50:0]        n_day_prod;
    logic [15:0]        n_days;
    logic [31:0]        n_day_secs;
    logic [16:0]        n_rem;
    logic [19:0]        n_dnum;
    logic [16:0]        n_wd_t;
    logic [33:0]        n_wd_prod;
    logic [34:0]        n_hour_prod;
    logic [4:0]         n_hour;
    logic [16:0]        n_wd_mul;
    logic [2:0]         n_wday;
    logic [19:0]        n_dnum2;
    logic [58:0]        n_year_prod;
    logic [11:0]        n_yest;
    logic [16:0]        n_hour_secs;
    logic [11:0]        n_rsec;
    logic [24:0]        n_cent_prod;
    logic [19:0]        n_y365;
    logic [24:0]        n_min_prod;
    logic [19:0]        n_dby;
    logic [10:0]        n_yday_raw;
    logic               n_leap;
    logic [11:0]        n_sec_full;
    logic [8:0]         n_yday;
    logic [11:0]        n_year;
    logic [8:0]         n_mon_arg;
    logic [25:0]        n_mon_prod;
    logic [8:0]         n_mday_full;
    edc_pkg::t_date_item n_out;

    // The pipeline moves when the output register is empty or being taken.
    assign w_adv        = !r_vld[NUM_STAGES-1] || o_date.ready;
    assign i_time.ready = w_adv;
    assign o_date.valid = r_vld[NUM_STAGES-1];
    assign o_date.payload = r_out;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], i_time.valid};
        end
    end

    // Stage 1: whole days, as (seconds >> 7) / 675.
    always_comb begin
        n_day_prod = 51'(r_s0_secs[31:7]) * 51'(edc_pkg::DAY_RECIP);
        n_days     = n_day_prod[edc_pkg::DAY_SHIFT+15:edc_pkg::DAY_SHIFT];
    end

    // Stage 2: seconds of the day, March-based day number, weekday quotient.
    always_comb begin
        n_day_secs = 32'(r_s1_days) * 32'(edc_pkg::SECS_PER_DAY);
        n_rem      = 17'(r_s1_secs - n_day_secs);
        n_dnum     = 20'(r_s1_days) + 20'(edc_pkg::MARCH_DAY_OFS);
        n_wd_t     = 17'(r_s1_days) + 17'(edc_pkg::EPOCH_WEEKDAY);
        n_wd_prod  = 34'(n_wd_t) * 34'(edc_pkg::WDAY_RECIP);
    end

    // Stage 3: hour, weekday remainder and the Gauss year estimate.
    always_comb begin
        n_hour_prod = 35'(r_s2_rem) * 35'(edc_pkg::HOUR_RECIP);
        n_hour      = n_hour_prod[edc_pkg::HOUR_SHIFT+4:edc_pkg::HOUR_SHIFT];
        n_wd_mul    = 17'(r_s2_wd_q) * 17'(edc_pkg::DAYS_PER_WEEK);
        n_wday      = 3'(r_s2_wd_t - n_wd_mul);
        n_dnum2     = r_s2_dnum + 20'd2;
        n_year_prod = 59'(n_dnum2) * 59'(edc_pkg::YEAR_RECIP);
        n_yest      = n_year_prod[edc_pkg::YEAR_SHIFT+11:edc_pkg::YEAR_SHIFT];
    end

    // Stage 4: seconds within the hour, century count and 365 * year.
    always_comb begin
        n_hour_secs = 17'(r_s3_hour) * 17'(edc_pkg::SECS_PER_HOUR);
        n_rsec      = 12'(r_s3_rem - n_hour_secs);
        n_cent_prod = 25'(r_s3_yest) * 25'(edc_pkg::CENT_RECIP);
        n_y365      = 20'(r_s3_yest) * 20'd365;
    end

    // Stage 5: minute, raw day of year and the leap flag of the estimate.
    always_comb begin
        n_min_prod = 25'(r_s4_rsec) * 25'(edc_pkg::MIN_RECIP);
        n_dby      = r_s4_y365 + 20'(r_s4_yest[11:2]) - 20'(r_s4_y100)
                   + 20'(r_s4_y100[4:2]);
        n_yday_raw = 11'(r_s4_dnum - n_dby);
        n_leap     = (r_s4_yest[1:0] == 2'd0)
                  && ((r_s4_yest != 12'(r_s4_y100) * 12'd100) || (r_s4_y100[1:0] == 2'd0));
    end

    // Stage 6: second, and the year correction when the day went negative.
    always_comb begin
        n_sec_full = r_s5_rsec - 12'(r_s5_min) * 12'(edc_pkg::SECS_PER_MIN);
        if (r_s5_yday_raw[10]) begin
            n_yday = 9'(r_s5_yday_raw + 11'sd365 + 11'(r_s5_leap));
            n_year = r_s5_yest - 12'd1;
        end else begin
            n_yday = 9'(r_s5_yday_raw);
            n_year = r_s5_yest;
        end
    end

    // Stage 7: March-based month from the day of year.
    always_comb begin
        n_mon_arg  = r_s6_yday + 9'd31;
        n_mon_prod = 26'(n_mon_arg) * 26'(edc_pkg::MON_RECIP);
    end

    // Stage 8: day of month and the shift back to a January-based year.
    always_comb begin
        n_mday_full            = r_s7_yday + 9'd1 - edc_pkg::month_offset(r_s7_mon);
        n_out.second_of_minute = r_s7_sec;
        n_out.minute_of_hour   = r_s7_min;
        n_out.hour_of_day      = r_s7_hour;
        n_out.day_of_month     = n_mday_full[4:0];
        n_out.weekday          = r_s7_wday;
        if (r_s7_yday >= 9'(edc_pkg::MARCH_BASE_DAY)) begin
            n_out.month_number  = r_s7_mon - 4'd10;
            n_out.calendar_year = r_s7_year + 12'd1;
        end else begin
            n_out.month_number  = r_s7_mon + 4'd2;
            n_out.calendar_year = r_s7_year;
        end
    end

    // Payload registers, all held while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_secs     <= i_time.payload.epoch_seconds;

            r_s1_secs     <= r_s0_secs;
            r_s1_days     <= n_days;

            r_s2_rem      <= n_rem;
            r_s2_dnum     <= n_dnum;
            r_s2_wd_t     <= n_wd_t;
            r_s2_wd_q     <= n_wd_prod[edc_pkg::WDAY_SHIFT+12:edc_pkg::WDAY_SHIFT];

            r_s3_rem      <= r_s2_rem;
            r_s3_hour     <= n_hour;
            r_s3_wday     <= n_wday;
            r_s3_dnum     <= r_s2_dnum;
            r_s3_yest     <= n_yest;

            r_s4_rsec     <= n_rsec;
            r_s4_hour     <= r_s3_hour;
            r_s4_wday     <= r_s3_wday;
            r_s4_dnum     <= r_s3_dnum;
            r_s4_yest     <= r_s3_yest;
            r_s4_y100     <= n_cent_prod[edc_pkg::CENT_SHIFT+4:edc_pkg::CENT_SHIFT];
            r_s4_y365     <= n_y365;

            r_s5_rsec     <= r_s4_rsec;
            r_s5_min      <= n_min_prod[edc_pkg::MIN_SHIFT+5:edc_pkg::MIN_SHIFT];
            r_s5_hour     <= r_s4_hour;
            r_s5_wday     <= r_s4_wday;
            r_s5_yday_raw <= n_yday_raw;
            r_s5_leap     <= n_leap;
            r_s5_yest     <= r_s4_yest;

            r_s6_sec      <= n_sec_full[5:0];
            r_s6_min      <= r_s5_min;
            r_s6_hour     <= r_s5_hour;
            r_s6_wday     <= r_s5_wday;
            r_s6_yday     <= n_yday;
            r_s6_year     <= n_year;

            r_s7_sec      <= r_s6_sec;
            r_s7_min      <= r_s6_min;
            r_s7_hour     <= r_s6_hour;
            r_s7_wday     <= r_s6_wday;
            r_s7_yday     <= r_s6_yday;
            r_s7_year     <= r_s6_year;
            r_s7_mon      <= n_mon_prod[edc_pkg::MON_SHIFT+3:edc_pkg::MON_SHIFT];

            r_out         <= n_out;
        end
    end

    // After the leap-year correction the day of year is within one year.
    a_yday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r_s6_yday <= 9'd365))
        else $error("day of year out of range after correction");

    // Every delivered date names a real month and day.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_date.valid |-> (o_date.payload.month_number >= 4'd1)
                      && (o_date.payload.month_number <= 4'd12)
                      && (o_date.payload.day_of_month >= 5'd1))
        else $error("month or day of month out of range");

    // Every delivered time of day and weekday is in range.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_date.valid |-> (o_date.payload.hour_of_day <= 5'd23)
                      && (o_date.payload.minute_of_hour <= 6'd59)
                      && (o_date.payload.second_of_minute <= 6'd59)
                      && (o_date.payload.weekday <= 3'd6))
        else $error("time of day or weekday out of range");

endmodule

// ----- dv/epoch_seconds_to_utc_date_tb.sv -----
// Testbench for epoch_seconds_to_utc_date: drives timestamps, predicts each UTC date
// and checks every output transfer in order. Depends on edc_pkg, edc_stream_if and the RTL.
module epoch_seconds_to_utc_date_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int PIPE_LATENCY = 9;
    localparam int IDLE_MAX     = 18;
    localparam int HOLD_CYCLES  = 250;
    localparam int BURST_ITEMS  = 40;
    localparam int CHUNKS       = 18;
    localparam int CHUNK_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LAST_DAY     = 49709;

    // Gregorian leap rule, used by the date predictor and by the stimulus.
    function automatic bit is_leap_year(longint unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // Tracks timestamps in flight and the dates they must produce.
    class date_scoreboard;
        typedef struct {
            logic [31:0]         secs;
            edc_pkg::t_date_item date;
        } t_pending_date;

        t_pending_date pending_dates[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        function int pending();
            return pending_dates.size();
        endfunction

        // Broken-down UTC time of a timestamp. The date is found by counting
        // days from March 1 of year 0, estimating the year with Gauss' formula.
        function edc_pkg::t_date_item civil_date_of(logic [31:0] secs);
            longint unsigned     total;
            longint unsigned     days;
            longint unsigned     rem;
            longint unsigned     yr;
            longint unsigned     mo;
            longint unsigned     yd;
            longint              yday_s;
            edc_pkg::t_date_item d;
            total = secs;
            days  = total / edc_pkg::SECS_PER_DAY;
            rem   = total % edc_pkg::SECS_PER_DAY;
            d.weekday          = 3'((edc_pkg::EPOCH_WEEKDAY + days) % edc_pkg::DAYS_PER_WEEK);
            d.hour_of_day      = 5'(rem / edc_pkg::SECS_PER_HOUR);
            d.minute_of_hour   = 6'((rem % edc_pkg::SECS_PER_HOUR) / edc_pkg::SECS_PER_MIN);
            d.second_of_minute = 6'(rem % edc_pkg::SECS_PER_MIN);

            days   = days - edc_pkg::JAN_FEB_DAYS + edc_pkg::DAYS_TO_EPOCH;
            yr     = (days + 2) * 400 / edc_pkg::DAYS_IN_400Y;
            yday_s = longint'(days) - longint'(365 * yr + yr / 4 - yr / 100 + yr / 400);
            // The estimate can overshoot by one year near the March start.
            if (yday_s < 0) begin
                yday_s = 365 + (is_leap_year(yr) ? 1 : 0) + yday_s;
                yr--;
            end
            yd = unsigned'(yday_s);
            mo = (yd + 31) * 10 / edc_pkg::MARCH_BASE_DAY;
            d.day_of_month = 5'(yd - (367 * mo / 12 - 30) + 1);
            // Move from a March-based year back to January.
            if (yd >= edc_pkg::MARCH_BASE_DAY) begin
                yr++;
                mo -= 10;
            end else begin
                mo += 2;
            end
            d.month_number  = 4'(mo);
            d.calendar_year = 12'(yr);
            return d;
        endfunction

        function void note_time(logic [31:0] secs);
            t_pending_date p;
            p.secs = secs;
            p.date = civil_date_of(secs);
            pending_dates.push_back(p);
        endfunction

        task check_date(edc_pkg::t_date_item got);
            t_pending_date p;
            if (pending_dates.size() == 0) begin
                report($sformatf("date %0d-%0d-%0d with no timestamp in flight",
                                 got.calendar_year, got.month_number, got.day_of_month));
                return;
            end
            p = pending_dates.pop_front();
            if (got.second_of_minute !== p.date.second_of_minute)
                report($sformatf("t=%0d second %0d, want %0d", p.secs,
                                 got.second_of_minute, p.date.second_of_minute));
            if (got.minute_of_hour !== p.date.minute_of_hour)
                report($sformatf("t=%0d minute %0d, want %0d", p.secs,
                                 got.minute_of_hour, p.date.minute_of_hour));
            if (got.hour_of_day !== p.date.hour_of_day)
                report($sformatf("t=%0d hour %0d, want %0d", p.secs,
                                 got.hour_of_day, p.date.hour_of_day));
            if (got.day_of_month !== p.date.day_of_month)
                report($sformatf("t=%0d day %0d, want %0d", p.secs,
                                 got.day_of_month, p.date.day_of_month));
            if (got.month_number !== p.date.month_number)
                report($sformatf("t=%0d month %0d, want %0d", p.secs,
                                 got.month_number, p.date.month_number));
            if (got.calendar_year !== p.date.calendar_year)
                report($sformatf("t=%0d year %0d, want %0d", p.secs,
                                 got.calendar_year, p.date.calendar_year));
            if (got.weekday !== p.date.weekday)
                report($sformatf("t=%0d weekday %0d, want %0d", p.secs,
                                 got.weekday, p.date.weekday));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    edc_stream_if #(.T(edc_pkg::t_time_item)) time_if ();
    edc_stream_if #(.T(edc_pkg::t_date_item)) date_if ();

    epoch_seconds_to_utc_date i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_time  (time_if),
        .o_date  (date_if)
    );

    date_scoreboard sb = new();

    int send_idle_max = 0;
    int recv_idle_max = 0;
    bit hold_request  = 0;
    int cycle_count   = 0;

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int draw_idle(int max_idle);
        return (max_idle == 0) ? 0 : $urandom_range(0, max_idle);
    endfunction

    // Random timestamp: half fully random, the rest on day, month and year edges.
    function automatic logic [31:0] pick_seconds();
        longint unsigned yr;
        longint unsigned day;
        longint unsigned secs;
        case ($urandom_range(0, 3))
            0, 1: begin
                secs = $urandom();
            end
            2: begin
                day  = $urandom_range(0, LAST_DAY);
                secs = day * edc_pkg::SECS_PER_DAY
                     + ($urandom_range(0, 1) ? edc_pkg::SECS_PER_DAY - 1 : 0);
            end
            default: begin
                // January 1 or March 1 of a random year, or the second before it.
                yr  = $urandom_range(1971, 2105);
                day = 365 * (yr - 1970) + (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400 - 477;
                if ($urandom_range(0, 1))
                    day += edc_pkg::JAN_FEB_DAYS + (is_leap_year(yr) ? 1 : 0);
                secs = day * edc_pkg::SECS_PER_DAY - 64'($urandom_range(0, 1));
            end
        endcase
        return secs[31:0];
    endfunction

    // One input transfer, after a random idle gap.
    task send_time(logic [31:0] secs);
        int gap;
        gap = draw_idle(send_idle_max);
        if (gap > 0) begin
            time_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        time_if.valid                 <= 1'b1;
        time_if.payload.epoch_seconds <= secs;
        do @(posedge i_clk); while (!time_if.ready);
        sb.note_time(secs);
    endtask

    task wait_all_dates();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls per item, and one long hold when asked.
    initial begin
        int stall;
        date_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 0;
            end else begin
                stall = draw_idle(recv_idle_max);
            end
            if (stall > 0) begin
                date_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            date_if.ready <= 1'b1;
            do @(posedge i_clk); while (!date_if.valid);
            sb.check_date(date_if.payload);
        end
    end

    // Stimulus and final verdict.
    initial begin
        logic [31:0] landmark_secs[$];
        int          idle_choice[3];
        landmark_secs = '{
            32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd31535999, 32'd31536000,        // end of 1970, start of 1971
            32'd68169600, 32'd68255999,        // 1972-02-29, the leap day
            32'd946684800, 32'd951868799,      // 2000-01-01, end of 2000-02-29
            32'd951868800,                     // 2000-03-01
            32'd2147483647, 32'd2147483648,    // around the sign bit
            32'd4107542399, 32'd4107542400,    // 2100 is not a leap year
            32'hAAAAAAAA, 32'h55555555,
            32'd4294944000, 32'd4294967294, 32'hFFFFFFFF
        };
        idle_choice = '{0, 4, IDLE_MAX};

        i_rst_n                       <= 1'b0;
        time_if.valid                 <= 1'b0;
        time_if.payload.epoch_seconds <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed timestamps with light idling on both sides.
        send_idle_max = 4;
        recv_idle_max = 4;
        foreach (landmark_secs[k]) send_time(landmark_secs[k]);
        time_if.valid <= 1'b0;
        wait_all_dates();

        // Back-to-back burst against a long output stall, so the input backs up.
        send_idle_max = 0;
        recv_idle_max = 0;
        hold_request  = 1;
        repeat (BURST_ITEMS) send_time(pick_seconds());
        time_if.valid <= 1'b0;
        wait_all_dates();

        // Random timestamps in chunks, each with its own idling on both sides.
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            send_idle_max = idle_choice[$urandom_range(0, 2)];
            recv_idle_max = idle_choice[$urandom_range(0, 2)];
            repeat (CHUNK_ITEMS) send_time(pick_seconds());
            if (chunk == CHUNKS / 2) begin
                time_if.valid <= 1'b0;
                wait_all_dates();
            end
        end
        time_if.valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray transfer.
        wait_all_dates();
        repeat (3 * PIPE_LATENCY) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
